// ----- hdl/pidc_pkg.sv -----
package pidc_pkg;

  // Field and state widths.
  localparam int DATA_WIDTH = 32;
  localparam int SUM_WIDTH  = 48;
  localparam int GAIN_WIDTH = 24;
  localparam int TIME_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Derived datapath widths.
  localparam int DIFF_W     = DATA_WIDTH + 1;
  localparam int PROD_W     = GAIN_WIDTH + DIFF_W;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int DIVIDEND_W = SUM_WIDTH + FRAC_BITS;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // The integral term magnitude is clamped to 2^TERM_LIMIT_LOG.
  localparam int TERM_LIMIT_LOG = 58;
  localparam int LIMIT_W        = TERM_LIMIT_LOG + 1;
  localparam int CMP_W          = (DIVIDEND_W > LIMIT_W) ? DIVIDEND_W : LIMIT_W;
  localparam int ACC_W          = TERM_LIMIT_LOG + 3;

  // Register reset values.
  localparam logic [GAIN_WIDTH-1:0] GAIN_P_RESET        = GAIN_WIDTH'(65536);
  localparam logic [TIME_WIDTH-1:0] INTEGRAL_TIME_RESET = '0;
  localparam logic [GAIN_WIDTH-1:0] GAIN_D_RESET        = '0;

  // Register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P        = 2'd0,
    CFG_INTEGRAL_TIME = 2'd1,
    CFG_GAIN_D        = 2'd2
  } cfg_index_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_ADD_D,
    ST_DIV,
    ST_INT,
    ST_FINISH,
    ST_OUTPUT
  } state_e;

  // Datapath controls from the sequencer.
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic mul_sel_d;
    logic diff_en;
    logic div_start;
    logic acc_load;
    logic acc_add_term;
    logic int_en;
    logic acc_add_int;
    logic out_load;
  } ctrl_t;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/pidc_divider.sv -----
module pidc_divider import pidc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [TIME_WIDTH-1:0] divisor_i,
  output div_stat_t             stat_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [TIME_WIDTH:0]   shifted;
  logic [TIME_WIDTH+1:0] trial;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor_i};
    fits    = !trial[TIME_WIDTH+1];
  end

  // Step sequencing. The quotient bits shift into the vacated dividend bits.
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (ctrl_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? trial[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

// ----- hdl/pid_controller_step.sv -----
// One PID step per transaction on a signed Q16.16 error sample: the error is
// added to a saturating 48-bit sum, and drive = gain_p*e + sum/integral_time +
// gain_d*(e - previous e), clipped to 32 bits, with saturated set when the
// drive or the sum was clipped. An integral_time of zero drops the integral
// term. The sum is divided by a restoring divider, which produces one bit of
// the 64-bit quotient per cycle; the two gain products share one 24x33
// multiplier as the divider is started and while it runs. The input is
// stalled while a sample is in progress, including while its result waits
// for the output register; a finished result waits in the output register,
// and the next sample is taken meanwhile. The configuration port is always
// ready and may be written only while the block is idle.
module pid_controller_step import pidc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] error_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] drive_o,
  output logic                         saturated_o
);

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] DRIVE_MAX =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DRIVE_MIN =
    {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [CMP_W-1:0] TERM_LIMIT = CMP_W'(1) << TERM_LIMIT_LOG;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;

  logic [GAIN_WIDTH-1:0] gain_p_q, gain_d_q;
  logic [TIME_WIDTH-1:0] integral_time_q;

  logic [SUM_WIDTH-1:0]  error_sum_q;
  logic [DATA_WIDTH-1:0] previous_error_q;

  logic [DIFF_W-1:0]     e_mag_q, diff_q, diff_mag_q;
  logic                  e_neg_q, sum_clip_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  prod_neg_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0]      int_q;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] drive_q;
  logic                  saturated_q;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_ADD_D;
      ST_ADD_D:  state_d = ST_DIV;
      ST_DIV:    if (div_stat.done) state_d = ST_INT;
      ST_INT:    state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUTPUT;
      ST_OUTPUT: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: datapath controls.
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: ctrl.accept = in_valid_i;
      ST_MUL_P: begin
        ctrl.mul_en    = 1'b1;
        ctrl.diff_en   = 1'b1;
        ctrl.div_start = 1'b1;
      end
      ST_MUL_D: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel_d = 1'b1;
        ctrl.acc_load  = 1'b1;
      end
      ST_ADD_D:  ctrl.acc_add_term = 1'b1;
      ST_DIV:    ctrl = '0;
      ST_INT:    ctrl.int_en = 1'b1;
      ST_FINISH: ctrl.acc_add_int = 1'b1;
      ST_OUTPUT: ctrl.out_load = !out_valid_q || !out_stall_i;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q        <= GAIN_P_RESET;
      integral_time_q <= INTEGRAL_TIME_RESET;
      gain_d_q        <= GAIN_D_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAIN_P:        gain_p_q        <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_INTEGRAL_TIME: integral_time_q <= cfg_data_i[TIME_WIDTH-1:0];
        CFG_GAIN_D:        gain_d_q        <= cfg_data_i[GAIN_WIDTH-1:0];
        default:           gain_p_q        <= gain_p_q;
      endcase
    end
  end

  // Saturating sum update and the exact error difference at acceptance.
  logic [SUM_WIDTH:0]   sum_ext;
  logic                 sum_ovf;
  logic [SUM_WIDTH-1:0] sum_new;
  logic [DIFF_W-1:0]    e_ext, prev_ext;

  always_comb begin
    sum_ext  = {error_sum_q[SUM_WIDTH-1], error_sum_q}
             + {{(SUM_WIDTH-DATA_WIDTH+1){error_sample_i[DATA_WIDTH-1]}}, error_sample_i};
    sum_ovf  = sum_ext[SUM_WIDTH] ^ sum_ext[SUM_WIDTH-1];
    sum_new  = sum_ovf ? (sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX)
                       : sum_ext[SUM_WIDTH-1:0];
    e_ext    = {error_sample_i[DATA_WIDTH-1], error_sample_i};
    prev_ext = {previous_error_q[DATA_WIDTH-1], previous_error_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q      <= '0;
      previous_error_q <= '0;
    end else if (ctrl.accept) begin
      error_sum_q      <= sum_new;
      previous_error_q <= error_sample_i;
    end
  end

  // Shared multiplier for the proportional and derivative products.
  logic [GAIN_WIDTH-1:0] mul_a;
  logic [DIFF_W-1:0]     mul_b;
  logic [PROD_W-1:0]     prod_d;

  always_comb begin
    mul_a  = ctrl.mul_sel_d ? gain_d_q : gain_p_q;
    mul_b  = ctrl.mul_sel_d ? diff_mag_q : e_mag_q;
    prod_d = {{DIFF_W{1'b0}}, mul_a} * {{GAIN_WIDTH{1'b0}}, mul_b};
  end

  // Signed product term, truncated toward zero to Q16.16.
  logic [TERM_W-1:0] term_mag;
  logic [ACC_W-1:0]  term_ext, term_s;

  always_comb begin
    term_mag = prod_q[PROD_W-1:FRAC_BITS];
    term_ext = {{(ACC_W-TERM_W){1'b0}}, term_mag};
    term_s   = prod_neg_q ? (~term_ext + ACC_W'(1)) : term_ext;
  end

  // Dividend is |error_sum| in Q.32 so the quotient lands in Q16.16.
  logic                  sum_neg;
  logic [SUM_WIDTH-1:0]  sum_mag;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;

  always_comb begin
    sum_neg        = error_sum_q[SUM_WIDTH-1];
    sum_mag        = sum_neg ? (~error_sum_q + SUM_WIDTH'(1)) : error_sum_q;
    dividend       = {sum_mag, {FRAC_BITS{1'b0}}};
    div_ctrl.start = ctrl.div_start;
  end

  pidc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (integral_time_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Integral term: clamp the magnitude, apply the sign of the sum.
  logic [CMP_W-1:0]   q_cmp;
  logic [LIMIT_W-1:0] int_mag;
  logic [ACC_W-1:0]   int_ext, int_d;

  always_comb begin
    q_cmp   = CMP_W'(quotient);
    int_mag = (q_cmp > TERM_LIMIT) ? TERM_LIMIT[LIMIT_W-1:0] : q_cmp[LIMIT_W-1:0];
    int_ext = {{(ACC_W-LIMIT_W){1'b0}}, int_mag};
    if (integral_time_q == '0) begin
      int_d = '0;
    end else begin
      int_d = sum_neg ? (~int_ext + ACC_W'(1)) : int_ext;
    end
  end

  // Accumulator of the three terms.
  always_comb begin
    acc_d = acc_q;
    if (ctrl.acc_load) begin
      acc_d = term_s;
    end else if (ctrl.acc_add_term) begin
      acc_d = acc_q + term_s;
    end else if (ctrl.acc_add_int) begin
      acc_d = acc_q + int_q;
    end
  end

  // Payload registers of the working item.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      e_mag_q    <= e_ext[DIFF_W-1] ? (~e_ext + DIFF_W'(1)) : e_ext;
      e_neg_q    <= e_ext[DIFF_W-1];
      diff_q     <= e_ext - prev_ext;
      sum_clip_q <= sum_ovf;
    end
    if (ctrl.diff_en) begin
      diff_mag_q <= diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
    end
    if (ctrl.mul_en) begin
      prod_q     <= prod_d;
      prod_neg_q <= ctrl.mul_sel_d ? diff_q[DIFF_W-1] : e_neg_q;
    end
    if (ctrl.int_en) begin
      int_q <= int_d;
    end
    acc_q <= acc_d;
  end

  // Output saturation into the result register.
  logic                  sat_hi, sat_lo;
  logic [DATA_WIDTH-1:0] drive_d;

  always_comb begin
    sat_hi  = acc_q > DRIVE_MAX;
    sat_lo  = acc_q < DRIVE_MIN;
    drive_d = sat_hi ? DRIVE_MAX[DATA_WIDTH-1:0]
            : (sat_lo ? DRIVE_MIN[DATA_WIDTH-1:0] : acc_q[DATA_WIDTH-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ctrl.out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      drive_q     <= drive_d;
      saturated_q <= sat_hi || sat_lo || sum_clip_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = saturated_q;

endmodule

// ----- hdl/pidc_checker.sv -----
module pidc_checker import pidc_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [DATA_WIDTH-1:0] drive_o,
  input logic                         saturated_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(drive_o) && $stable(saturated_o))
    else $error("result payload changed while stalled");

  // An accepted sample keeps the input stalled while it is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a sample was accepted");

  // No result can appear in the cycle right after a sample is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after acceptance");

endmodule

bind pid_controller_step pidc_checker u_checker (.*);

// ----- verif/pid_controller_step_tb.sv -----
`timescale 1ns / 1ps

module pid_controller_step_tb;
  import pidc_pkg::*;

  localparam int          SETTLE_CYCLES   = 8;
  localparam int          END_CYCLES      = 80;
  localparam int          RANDOM_PHASES   = 5;
  localparam int          ITEMS_PER_PHASE = 100;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  // Index 3 maps to no register, so a write there must leave all settings alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = '1;

  localparam longint SUM_MAX   = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
  localparam longint SUM_MIN   = -SUM_MAX - 64'sd1;
  localparam longint DRIVE_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 64'sd1;
  localparam longint unsigned TERM_CAP = 64'd1 << TERM_LIMIT_LOG;

  localparam logic signed [DATA_WIDTH-1:0] ERROR_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] ERROR_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic [DATA_WIDTH-1:0] drive;
    logic                  saturated;
  } drive_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_INDEX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [DATA_WIDTH-1:0] error_sample_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [DATA_WIDTH-1:0] drive_o;
  logic                         saturated_o;

  bit          no_idle = 1'b0;
  int unsigned idle_cycles = 0;

  // Controller state and settings, plus the drives still owed by the block.
  class drive_scoreboard;
    logic [GAIN_WIDTH-1:0] gain_p;
    logic [TIME_WIDTH-1:0] integral_time;
    logic [GAIN_WIDTH-1:0] gain_d;
    longint                error_sum;
    longint                previous_error;
    drive_result_t         expected_drives[$];
    int unsigned           mismatches;

    function new();
      gain_p         = GAIN_P_RESET;
      integral_time  = INTEGRAL_TIME_RESET;
      gain_d         = GAIN_D_RESET;
      error_sum      = 0;
      previous_error = 0;
      mismatches     = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_GAIN_P:        gain_p = data[GAIN_WIDTH-1:0];
        CFG_INTEGRAL_TIME: integral_time = data[TIME_WIDTH-1:0];
        CFG_GAIN_D:        gain_d = data[GAIN_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Gain product in Q16.16, truncated toward zero.
    function longint scale_by_gain(logic [GAIN_WIDTH-1:0] gain, longint value);
      longint unsigned mag;
      longint unsigned prod;
      mag  = (value < 0) ? -value : value;
      prod = (mag * gain) >> FRAC_BITS;
      return (value < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // One controller step for an accepted error sample.
    function void note_sample(logic signed [DATA_WIDTH-1:0] sample);
      longint          e;
      longint          i_term;
      longint          total;
      longint unsigned mag;
      drive_result_t   result;
      e                = sample;
      i_term           = 0;
      result.saturated = 1'b0;

      // The error sum clips at the signed sum range and keeps the clipped value.
      if (e > 0 && error_sum > SUM_MAX - e) begin
        error_sum        = SUM_MAX;
        result.saturated = 1'b1;
      end else if (e < 0 && error_sum < SUM_MIN - e) begin
        error_sum        = SUM_MIN;
        result.saturated = 1'b1;
      end else begin
        error_sum += e;
      end

      // A zero integral time drops the integral term; its magnitude is capped.
      if (integral_time != '0) begin
        mag = (error_sum < 0) ? -error_sum : error_sum;
        mag = (mag << FRAC_BITS) / integral_time;
        if (mag > TERM_CAP) mag = TERM_CAP;
        i_term = (error_sum < 0) ? -longint'(mag) : longint'(mag);
      end

      total = scale_by_gain(gain_p, e) + i_term + scale_by_gain(gain_d, e - previous_error);
      if (total > DRIVE_MAX) begin
        total            = DRIVE_MAX;
        result.saturated = 1'b1;
      end else if (total < DRIVE_MIN) begin
        total            = DRIVE_MIN;
        result.saturated = 1'b1;
      end
      previous_error = e;

      result.drive = total[DATA_WIDTH-1:0];
      expected_drives.push_back(result);
    endfunction

    function void check_drive(logic signed [DATA_WIDTH-1:0] drive, logic saturated);
      drive_result_t want;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive %0d saturated %0b",
                 $time, drive, saturated);
        mismatches++;
        return;
      end
      want = expected_drives.pop_front();
      if (drive !== $signed(want.drive)) begin
        $display("%0t: drive mismatch, expected %0d, actual %0d",
                 $time, $signed(want.drive), drive);
        mismatches++;
      end
      if (saturated !== want.saturated) begin
        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                 $time, want.saturated, saturated);
        mismatches++;
      end
    endfunction
  endclass

  drive_scoreboard drives;

  pid_controller_step u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .error_sample_i (error_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .saturated_o    (saturated_o)
  );

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every transaction on the three channels goes through the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) drives.write_register(cfg_index_i, cfg_data_i);
      if (out_valid_o && !out_stall_i) drives.check_drive(drive_o, saturated_o);
      if (in_valid_i && !in_stall_o) drives.note_sample(error_sample_i);
    end
  end

  // A long stretch with no transaction at all means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side stalls in short random bursts, except in the final phase.
  initial begin : result_backpressure
    int unsigned hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        hold        = $urandom_range(1, 4) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_WIDTH-1:0] sample);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    error_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off new samples until every owed drive has come back.
  task automatic wait_for_drives(input int unsigned extra_cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drives.expected_drives.size() != 0) @(negedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  // Gain word with random upper bits, so register masking is exercised.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    case ($urandom_range(0, 3))
      0: word[GAIN_WIDTH-1:0] = '0;
      1: word[GAIN_WIDTH-1:0] = '1;
      2: word[GAIN_WIDTH-1:0] = GAIN_P_RESET;
      default: ;
    endcase
    return word;
  endfunction

  initial begin : stimulus
    logic signed [DATA_WIDTH-1:0] directed[$];
    logic signed [DATA_WIDTH-1:0] sample;
    logic [CFG_DATA_W-1:0]        time_word;
    drives         = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_GAIN_P;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    error_sample_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: unity proportional gain, no integral, no derivative.
    directed = '{32'sd0, 32'sd1, -32'sd1, ERROR_MAX, ERROR_MIN, 32'sh10000, -32'sh10000};
    foreach (directed[k]) send_sample(directed[k]);

    // Largest gains and the smallest nonzero integral time drive the output into both rails.
    wait_for_drives(SETTLE_CYCLES);
    write_setting(CFG_GAIN_P, 32'hFFFF_FFFF);
    write_setting(CFG_INTEGRAL_TIME, 32'd1);
    write_setting(CFG_GAIN_D, 32'hFFFF_FFFF);
    write_setting(CFG_UNUSED, 32'h0000_1234);
    directed = '{ERROR_MAX, ERROR_MIN, ERROR_MAX, 32'sd0, -32'sd1, 32'sd1, ERROR_MIN};
    foreach (directed[k]) send_sample(directed[k]);

    // No proportional term, unity derivative gain, and the largest integral divisor.
    wait_for_drives(SETTLE_CYCLES);
    write_setting(CFG_GAIN_P, 32'd0);
    write_setting(CFG_INTEGRAL_TIME, 32'hFFFF_FFFF);
    write_setting(CFG_GAIN_D, 32'h0001_0000);
    directed = '{ERROR_MAX, ERROR_MAX, ERROR_MIN, 32'sd7};
    foreach (directed[k]) send_sample(directed[k]);

    // The error sum cannot clip here: that takes 2^16 full-scale samples in a row.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_drives(SETTLE_CYCLES);
      case ($urandom_range(0, 4))
        0:       time_word = '0;
        1:       time_word = 32'd1;
        2:       time_word = '1;
        3:       time_word = $urandom_range(1, 1 << 20);
        default: time_word = $urandom;
      endcase
      write_setting(CFG_GAIN_P, pick_gain());
      write_setting(CFG_INTEGRAL_TIME, time_word);
      write_setting(CFG_GAIN_D, pick_gain());
      if ($urandom_range(0, 3) == 0) write_setting(CFG_UNUSED, $urandom);
      if (phase == RANDOM_PHASES - 1) no_idle = 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 39) == 0) wait_for_drives(0);
        case ($urandom_range(0, 9))
          0:       sample = ERROR_MAX;
          1:       sample = ERROR_MIN;
          2:       sample = '0;
          3, 4, 5: sample = $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
          default: sample = $urandom;
        endcase
        send_sample(sample);
      end
    end

    wait_for_drives(END_CYCLES);
    if (drives.mismatches == 0 && drives.expected_drives.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
